// ===== rtl/tmsq_pkg.sv =====
// Shared types, codes and constant tables of the tone melody sequencer.
// No dependencies; every other file of the block imports this package.
package tmsq_pkg;

	// Request kinds carried on the input tuser
	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_SELECT = 2'd1;
	localparam logic [1:0] REQ_EFFECT = 2'd2;

	// Effect codes
	localparam logic [2:0] FX_MOVE       = 3'd0;
	localparam logic [2:0] FX_ERROR      = 3'd1;
	localparam logic [2:0] FX_MENU_SEL   = 3'd2;
	localparam logic [2:0] FX_MENU_BACK  = 3'd3;
	localparam logic [2:0] FX_MENU       = 3'd4;
	localparam logic [2:0] FX_LEVEL_DONE = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] CFG_MUSIC_EN  = 2'd0;
	localparam logic [1:0] CFG_EFFECT_EN = 2'd1;
	localparam logic [1:0] CFG_FRAME_RT  = 2'd2;

	localparam int unsigned FREQ_W   = 11;
	localparam int unsigned SUS_W    = 8;
	localparam int unsigned POS_W    = 4;
	localparam int unsigned TEMPO_W  = 8;
	localparam int unsigned SCALE_W  = 25;
	localparam int unsigned PROD_W   = SCALE_W + 8;
	// floor(x/1000) == (x * RECIP_1000) >> RECIP_SHIFT for every x below 2^16
	localparam int unsigned RECIP_SHIFT = 26;
	localparam int unsigned RECIP_1000  = 67109;
	localparam int unsigned FRAMES_W    = PROD_W - RECIP_SHIFT;

	// Position counts values, two per note pair; six pairs per tune
	localparam logic [POS_W-1:0] TUNE_VALUES = POS_W'(12);
	localparam logic [POS_W-1:0] POS_STEP    = POS_W'(2);
	localparam logic [TEMPO_W-1:0] TEMPO_MAX = TEMPO_W'(255);

	localparam logic [SUS_W-1:0] MOVE_SUSTAIN   = SUS_W'(16);
	localparam logic [SUS_W-1:0] EFFECT_SUSTAIN = SUS_W'(166);

	typedef struct packed {
		logic              music_enable;
		logic              effects_enable;
		logic [7:0]        frame_rate;
	} cfg_t;

	typedef struct packed {
		logic              tone_valid;
		logic [FREQ_W-1:0] tone_freq;
		logic [SUS_W-1:0]  tone_sustain;
		logic              music_playing;
	} result_t;

	// Note frequency of a tune pair
	function automatic logic [FREQ_W-1:0] tune_freq(input logic tune, input logic [2:0] pair);
		logic [FREQ_W-1:0] f;
		f = '0;
		case (pair)
			3'd0: f = FREQ_W'(523);
			3'd1: f = FREQ_W'(659);
			3'd2: f = tune ? FREQ_W'(784)  : FREQ_W'(783);
			3'd3: f = tune ? FREQ_W'(1047) : FREQ_W'(1046);
			3'd4: f = tune ? FREQ_W'(1319) : FREQ_W'(1318);
			default: f = '0;
		endcase
		return f;
	endfunction

	// Note duration in ms already multiplied by the reciprocal of 1000
	function automatic logic [SCALE_W-1:0] tune_scaled(input logic tune,
			input logic [2:0] pair);
		logic [SCALE_W-1:0] s;
		s = '0;
		case (pair)
			3'd0, 3'd1, 3'd2: s = SCALE_W'(50 * RECIP_1000);
			3'd3: s = tune ? SCALE_W'(75 * RECIP_1000)  : SCALE_W'(150 * RECIP_1000);
			3'd4: s = tune ? SCALE_W'(100 * RECIP_1000) : SCALE_W'(250 * RECIP_1000);
			default: s = '0;
		endcase
		return s;
	endfunction

	function automatic logic [FREQ_W-1:0] fx_freq(input logic [2:0] code);
		logic [FREQ_W-1:0] f;
		f = '0;
		case (code)
			FX_MOVE:      f = FREQ_W'(800);
			FX_ERROR:     f = FREQ_W'(210);
			FX_MENU_SEL:  f = FREQ_W'(1250);
			FX_MENU_BACK: f = FREQ_W'(1000);
			FX_MENU:      f = FREQ_W'(900);
			default:      f = '0;
		endcase
		return f;
	endfunction

	function automatic logic [SUS_W-1:0] fx_sustain(input logic [2:0] code);
		return (code == FX_MOVE) ? MOVE_SUSTAIN : EFFECT_SUSTAIN;
	endfunction

endpackage

// ===== rtl/tmsq_seq.sv =====
// Sequencer state and per-item result logic of the tone melody sequencer.
// Depends on tmsq_pkg; fed by the top level's input handshake and config registers.
module tmsq_seq
	import tmsq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       accept,
	input  logic [1:0] req_type,
	input  logic       tune_id,
	input  logic       loop_tune,
	input  logic [2:0] effect_code,
	output result_t    res
);

	logic                cur_tune_q;
	logic                loaded_q;
	logic [POS_W-1:0]    pos_q;
	logic [TEMPO_W-1:0]  tempo_q;
	logic                repeat_q;

	logic                cur_tune_d;
	logic                loaded_d;
	logic [POS_W-1:0]    pos_d;
	logic [TEMPO_W-1:0]  tempo_d;
	logic                repeat_d;

	logic [2:0]          pair;
	logic [POS_W-1:0]    pos_adv;
	logic [PROD_W-1:0]   prod;
	logic [FRAMES_W-1:0] frames;
	logic [TEMPO_W-1:0]  frames_sat;

	// Note duration in ticks: one multiply by the pre-scaled duration
	assign pair    = 3'(pos_q >> 1);
	assign prod    = PROD_W'(cfg.frame_rate) * PROD_W'(tune_scaled(cur_tune_q, pair));
	assign frames  = prod[PROD_W-1:RECIP_SHIFT];
	assign frames_sat = (TEMPO_W'(frames) > TEMPO_MAX) ? TEMPO_MAX : TEMPO_W'(frames);
	assign pos_adv = pos_q + POS_STEP;

	// Next state and result for the item at the input
	always_comb begin
		cur_tune_d       = cur_tune_q;
		loaded_d         = loaded_q;
		pos_d            = pos_q;
		tempo_d          = tempo_q;
		repeat_d         = repeat_q;
		res.tone_valid   = 1'b0;
		res.tone_freq    = '0;
		res.tone_sustain = '0;
		case (req_type)
			REQ_TICK: begin
				if (loaded_q) begin
					if (tempo_q != '0) begin
						tempo_d = tempo_q - TEMPO_W'(1);
					end else if (cfg.music_enable && pos_q < TUNE_VALUES) begin
						res.tone_valid = 1'b1;
						res.tone_freq  = tune_freq(cur_tune_q, pair);
						tempo_d        = frames_sat;
						pos_d          = (pos_adv >= TUNE_VALUES && repeat_q) ? '0 : pos_adv;
					end
				end
			end
			REQ_SELECT: begin
				cur_tune_d = tune_id;
				loaded_d   = 1'b1;
				pos_d      = '0;
				tempo_d    = '0;
				repeat_d   = loop_tune;
			end
			REQ_EFFECT: begin
				if (cfg.effects_enable) begin
					if (effect_code inside {[FX_MOVE:FX_MENU]}) begin
						res.tone_valid   = 1'b1;
						res.tone_freq    = fx_freq(effect_code);
						res.tone_sustain = fx_sustain(effect_code);
					end else if (effect_code == FX_LEVEL_DONE) begin
						// Start the first tune once, no repeat
						cur_tune_d = 1'b0;
						loaded_d   = 1'b1;
						pos_d      = '0;
						tempo_d    = '0;
						repeat_d   = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		res.music_playing = loaded_d && (pos_d < TUNE_VALUES);
	end

	// Update state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_tune_q <= 1'b0;
			loaded_q   <= 1'b0;
			pos_q      <= '0;
			tempo_q    <= '0;
			repeat_q   <= 1'b0;
		end else if (accept) begin
			cur_tune_q <= cur_tune_d;
			loaded_q   <= loaded_d;
			pos_q      <= pos_d;
			tempo_q    <= tempo_d;
			repeat_q   <= repeat_d;
		end
	end

`ifndef SYNTH
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!loaded_q |-> (pos_q == '0 && tempo_q == '0))
		else $error("position or tempo set with no tune loaded");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!pos_q[0] && pos_q <= TUNE_VALUES))
		else $error("note position out of range");
	a_tempo_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == REQ_TICK && loaded_q && tempo_q != '0)
		|=> tempo_q == $past(tempo_q) - TEMPO_W'(1))
		else $error("tempo count did not step down on a tick");
	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !res.tone_valid) |-> (res.tone_freq == '0 && res.tone_sustain == '0))
		else $error("payload set without a tone");
`endif

endmodule

// ===== rtl/tmsq_skid.sv =====
// Output register with a skid stage for the result items.
// Depends on tmsq_pkg for the result struct.
module tmsq_skid
	import tmsq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    push_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop        = out_valid_q && out_ready;
	assign push_ready = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	// Track occupancy of the output and skid slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// Move payload: refill from skid first, else take the new item
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			if (out_valid_q) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

endmodule

// ===== rtl/tone_melody_sequencer_core.sv =====
// Top level of the tone melody sequencer: stream ports, config registers.
// Depends on tmsq_pkg, tmsq_seq and tmsq_skid.
//
// Tone sequencer driven by request items: frame ticks step one of two built-in
// tunes, select requests load a tune, effect requests issue fixed tones or
// start the first tune once (level done). Every accepted item yields exactly
// one result item; a new item is taken every cycle as long as the output side
// keeps up. The result comes from the tune table, one 8x25 multiply for the
// note length and the state registers, all in the cycle of acceptance; an
// output register plus a skid slot let one more item in while a result waits.
// Config writes are taken in any cycle (cfg_ready is tied high) and only change
// behavior of later items; indexes beyond frame_rate are ignored.
module tone_melody_sequencer_core
	import tmsq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] tune_id, [1] loop_tune, [4:2] effect_code, [7:5] zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [10:0] tone_freq, [18:11] tone_sustain,
	                               // [19] music_playing, [23:20] zero
	output logic        m_tuser,   // [0] tone_valid
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t    cfg_q;
	result_t res;
	result_t out_res;
	logic    in_accept;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.music_enable   <= 1'b0;
			cfg_q.effects_enable <= 1'b0;
			cfg_q.frame_rate     <= 8'd30;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MUSIC_EN:  cfg_q.music_enable   <= cfg_data[0];
				CFG_EFFECT_EN: cfg_q.effects_enable <= cfg_data[0];
				CFG_FRAME_RT:  cfg_q.frame_rate     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_accept = s_tvalid && s_tready;

	tmsq_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.accept      (in_accept),
		.req_type    (s_tuser),
		.tune_id     (s_tdata[0]),
		.loop_tune   (s_tdata[1]),
		.effect_code (s_tdata[4:2]),
		.res         (res)
	);

	tmsq_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_accept),
		.push_data  (res),
		.push_ready (s_tready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (out_res)
	);

	// Pack the result item
	assign m_tuser = out_res.tone_valid;
	assign m_tdata = {4'b0000, out_res.music_playing, out_res.tone_sustain, out_res.tone_freq};

endmodule
